@@ hw/rtl/gkph_pkg.sv @@
// Shared constants, types and command/status structs for the gapped k-mer hasher.
package gkph_pkg;

  localparam int SYM_W     = 6;
  localparam int POS_W     = 20;
  localparam int HASH_W    = 30;
  localparam int MAX_ELEM  = 8;
  localparam int WIN_DEPTH = 128;
  localparam int ADDR_W    = $clog2(WIN_DEPTH);
  localparam int FILL_W    = $clog2(WIN_DEPTH + 1);
  localparam int GAP_W     = 4;
  localparam int NGAPS     = MAX_ELEM - 1;
  localparam int ELEM_W    = $clog2(MAX_ELEM) + 1;
  localparam int IDX_W     = $clog2(MAX_ELEM);
  localparam int SPAN_W    = $clog2(1 + NGAPS * ((1 << GAP_W))) + 1;

  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_LENGTHS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALLOWED_MASK  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POSITIONAL    = 2'd3;

  // Hash arithmetic.
  localparam longint unsigned HASH_BASE = 64'd233;
  localparam longint unsigned HASH_MOD  = 64'd1000000033;
  localparam int X_W         = 38;  // h * 233 + symbol
  localparam int R_W         = 32;  // partial remainder, below three times the modulus
  localparam int HI_SHIFT    = 14;  // low hash bits dropped for the quotient estimate
  localparam int HI_W        = HASH_W - HI_SHIFT;
  localparam int QUOT_SHIFT  = 24;
  localparam int Q_W         = 8;
  localparam longint unsigned QUOT_MUL_FULL =
    (HASH_BASE << (HI_SHIFT + QUOT_SHIFT)) / HASH_MOD;
  localparam logic [HI_W-1:0] QUOT_MUL = HI_W'(QUOT_MUL_FULL);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_RED,
    ST_COR,
    ST_DONE
  } gkph_state_t;

  typedef struct packed {
    logic accept;
    logic step_mul;
    logic step_red;
    logic step_cor;
    logic load_out;
  } gkph_cmd_t;

  typedef struct packed {
    logic hit;
    logic last;
    logic ok;
    logic slot_free;
  } gkph_status_t;

endpackage

@@ hw/rtl/gkph_if.sv @@
// Valid/ready channel interfaces for the symbol input and the hash output.
interface gkph_sym_if;
  import gkph_pkg::*;
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic             first;

  modport source (output valid, output symbol, output first, input ready);
  modport sink (input valid, input symbol, input first, output ready);
endinterface

interface gkph_hash_if;
  import gkph_pkg::*;
  logic              valid;
  logic              ready;
  logic [HASH_W-1:0] window_hash;
  logic [POS_W-1:0]  start_position;

  modport source (output valid, output window_hash, output start_position, input ready);
  modport sink (input valid, input window_hash, input start_position, output ready);
endinterface

@@ hw/rtl/gapped_kmer_polynomial_hasher_core.sv @@
// Gapped k-mer polynomial hasher: one symbol per input transfer, at most one hash per symbol.
//
// Each accepted symbol is written into a 128-entry ring store; once the current sequence holds
// a full gapped window (element_count symbols, separated by the configured gaps), the chosen
// symbols are read back one at a time and folded into a Horner hash with base 233 modulo
// 1000000033, seeded with the window start position when positional mode is set. If every
// chosen symbol is allowed by allowed_mask, one result transfer carries the hash and the start
// position. A symbol that completes no window is accepted without leaving the idle state. A
// symbol that does complete one is accepted, waits in a load state for the first read of the
// ring store, then runs the shared multiply, reciprocal-based reduction and final correction
// states for each element in turn, and ends in a done state that hands the result to the output
// register. If the previous result is still waiting in the output register, the done state is
// held until the register is taken. The per-element multiply, reduction and correction loop sets
// the rate. The output register lets the next symbol be accepted while a finished result still
// waits to be taken. The ring store needs no clearing after reset, since only symbols of the
// current sequence are read. Configuration registers are written through a plain write port and
// should only change while the block is idle.
module gapped_kmer_polynomial_hasher_core
  import gkph_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  gkph_sym_if.sink              sym_in,
  gkph_hash_if.source           hash_out,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Command and status between the sequencer and the datapath.
  gkph_cmd_t    cmd;
  gkph_status_t status;

  // The sequencer owns the input handshake; the datapath owns the output register.
  gkph_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sym_in.valid),
    .in_ready (sym_in.ready),
    .status   (status),
    .cmd      (cmd)
  );

  gkph_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .symbol         (sym_in.symbol),
    .first          (sym_in.first),
    .cmd            (cmd),
    .status         (status),
    .out_valid      (hash_out.valid),
    .out_ready      (hash_out.ready),
    .window_hash    (hash_out.window_hash),
    .start_position (hash_out.start_position)
  );

endmodule

@@ hw/rtl/gkph_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module gkph_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/gkph_ctrl.sv @@
// Sequencer for the gapped k-mer hasher: admits symbols and steps the hash loop.
module gkph_ctrl
  import gkph_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  gkph_status_t status,
  output gkph_cmd_t    cmd
);

  gkph_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && status.hit) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: state_next = ST_MUL;
      ST_MUL:  state_next = ST_RED;
      ST_RED:  state_next = ST_COR;
      ST_COR: begin
        state_next = status.last ? ST_DONE : ST_MUL;
      end
      ST_DONE: begin
        if (!status.ok || status.slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_LOAD: ;
      ST_MUL:  cmd.step_mul = 1'b1;
      ST_RED:  cmd.step_red = 1'b1;
      ST_COR:  cmd.step_cor = 1'b1;
      ST_DONE: cmd.load_out = status.ok && status.slot_free;
      default: ;
    endcase
  end

  a_load_after_accept: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD) |-> $past(cmd.accept) && $past(status.hit))
    else $error("hash loop started without an accepted symbol completing a window");

  a_mul_entry: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL) |-> ($past(state) == ST_LOAD || $past(state) == ST_COR))
    else $error("multiply step entered out of sequence");

endmodule

@@ hw/rtl/gkph_datapath.sv @@
// Datapath: configuration, ring store, position tracking and the modular Horner step.
module gkph_datapath
  import gkph_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [SYM_W-1:0]      symbol,
  input  logic                  first,
  input  gkph_cmd_t             cmd,
  output gkph_status_t          status,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [HASH_W-1:0]     window_hash,
  output logic [POS_W-1:0]      start_position
);

  // Configuration registers.
  logic [ELEM_W-1:0]        element_count;
  logic [NGAPS*GAP_W-1:0]   gap_lengths;
  logic [(1<<SYM_W)-1:0]    allowed_mask;
  logic                     positional;

  // Sequence tracking.
  logic [POS_W-1:0]  symbol_count;
  logic [ADDR_W-1:0] wr_ptr;
  logic [FILL_W-1:0] fill_level;

  // Hash loop.
  logic [ADDR_W-1:0] rd_addr;
  logic [IDX_W-1:0]  elem_idx;
  logic [HASH_W-1:0] h;
  logic [X_W-1:0]    x;
  logic [Q_W-1:0]    q;
  logic [R_W-1:0]    r;
  logic              ok;
  logic [POS_W-1:0]  start_pos;
  logic [SYM_W-1:0]  rdata;

  logic [ELEM_W-1:0] k_eff;
  logic [SPAN_W-1:0] span;
  logic [SPAN_W-1:0] span_m1;
  logic [POS_W-1:0]  cnt_base;
  logic [FILL_W-1:0] fill_base;
  logic [FILL_W-1:0] fill_new;
  logic [POS_W-1:0]  start_pos_new;
  logic [ADDR_W-1:0] start_ring;
  logic [GAP_W-1:0]  cur_gap;
  logic [2*HI_W-1:0] q_prod;
  logic [R_W-1:0]    r_fixed;

  function automatic logic [GAP_W-1:0] gap_at(input logic [NGAPS*GAP_W-1:0] gaps,
                                              input logic [IDX_W-1:0] idx);
    logic [GAP_W-1:0] g;
    g = '0;
    for (int i = 0; i < NGAPS; i++) begin
      if (idx == IDX_W'(i)) begin
        g = gaps[i*GAP_W +: GAP_W];
      end
    end
    return g;
  endfunction

  gkph_ram #(
    .WIDTH (SYM_W),
    .DEPTH (WIN_DEPTH)
  ) u_window (
    .clk   (clk),
    .we    (cmd.accept),
    .waddr (wr_ptr),
    .wdata (symbol),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  always_comb begin
    if (element_count == '0) begin
      k_eff = ELEM_W'(1);
    end else if (element_count > ELEM_W'(MAX_ELEM)) begin
      k_eff = ELEM_W'(MAX_ELEM);
    end else begin
      k_eff = element_count;
    end
    span = SPAN_W'(1);
    for (int i = 0; i < NGAPS; i++) begin
      if (ELEM_W'(i + 1) < k_eff) begin
        span = span + SPAN_W'(gap_lengths[i*GAP_W +: GAP_W]) + SPAN_W'(1);
      end
    end
    span_m1 = span - SPAN_W'(1);
  end

  always_comb begin
    cnt_base  = first ? '0 : symbol_count;
    fill_base = first ? '0 : fill_level;
    fill_new  = (fill_base < FILL_W'(WIN_DEPTH)) ? fill_base + FILL_W'(1) : fill_base;
    start_pos_new = cnt_base - POS_W'(span_m1);
    start_ring    = wr_ptr - ADDR_W'(span_m1);
    cur_gap       = gap_at(gap_lengths, elem_idx);
    q_prod        = (2*HI_W)'(h[HASH_W-1:HI_SHIFT]) * (2*HI_W)'(QUOT_MUL);
    if (r >= R_W'(2 * HASH_MOD)) begin
      r_fixed = r - R_W'(2 * HASH_MOD);
    end else if (r >= R_W'(HASH_MOD)) begin
      r_fixed = r - R_W'(HASH_MOD);
    end else begin
      r_fixed = r;
    end
  end

  always_comb begin
    status.hit       = (span <= SPAN_W'(WIN_DEPTH)) &&
                       (FILL_W'(32'(fill_new)) >= FILL_W'(span));
    status.last      = (ELEM_W'(elem_idx) == k_eff - ELEM_W'(1));
    status.ok        = ok;
    status.slot_free = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= ELEM_W'(2);
      gap_lengths   <= '0;
      allowed_mask  <= '1;
      positional    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ELEMENT_COUNT: element_count <= cfg_data[ELEM_W-1:0];
        REG_GAP_LENGTHS:   gap_lengths   <= cfg_data[NGAPS*GAP_W-1:0];
        REG_ALLOWED_MASK:  allowed_mask  <= cfg_data[(1<<SYM_W)-1:0];
        REG_POSITIONAL:    positional    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_count <= '0;
      wr_ptr       <= '0;
      fill_level   <= '0;
    end else if (cmd.accept) begin
      symbol_count <= cnt_base + POS_W'(1);
      wr_ptr       <= wr_ptr + ADDR_W'(1);
      fill_level   <= fill_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      h         <= positional ? HASH_W'(start_pos_new) : '0;
      rd_addr   <= start_ring;
      elem_idx  <= '0;
      ok        <= 1'b1;
      start_pos <= start_pos_new;
    end
    if (cmd.step_mul) begin
      ok      <= ok && allowed_mask[rdata];
      x       <= X_W'(h) * X_W'(HASH_BASE) + X_W'(rdata);
      q       <= q_prod[QUOT_SHIFT +: Q_W];
      rd_addr <= rd_addr + ADDR_W'(cur_gap) + ADDR_W'(1);
    end
    if (cmd.step_red) begin
      r <= R_W'(x - X_W'(q) * X_W'(HASH_MOD));
    end
    if (cmd.step_cor) begin
      h        <= r_fixed[HASH_W-1:0];
      elem_idx <= elem_idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      window_hash    <= h;
      start_position <= start_pos;
    end
  end

  a_partial_rem: assert property (@(posedge clk) disable iff (rst)
    cmd.step_cor |-> (r < R_W'(3 * HASH_MOD)))
    else $error("quotient estimate left the remainder three or more moduli high");

  a_hash_reduced: assert property (@(posedge clk) disable iff (rst)
    cmd.step_cor |=> (h < HASH_W'(HASH_MOD)))
    else $error("hash register holds an unreduced value");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid && (window_hash == $past(h)))
    else $error("finished hash not presented on the output register");

endmodule
